// ===== sv/fabr_pkg.sv =====
// Package for the flame alarm beeper and report scheduler.
// Holds register indexes, reset values and field widths; no dependencies.
`timescale 1ns / 1ps
package fabr_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int NOW_W             = 32;
  localparam int APB_ADDR_W        = 5;
  localparam int APB_DATA_W        = 32;

  localparam int CONFIRM_W = 8;
  localparam int BEEP_W    = 16;
  localparam int HOLD_W    = 22;
  localparam int HBEAT_W   = 22;

  // Heartbeat wrap formula adds this constant when the clock has wrapped.
  localparam logic [NOW_W-1:0] HB_ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 8'd3;
  localparam logic [BEEP_W-1:0]    BEEP_ON_RESET  = 16'd500;
  localparam logic [BEEP_W-1:0]    BEEP_OFF_RESET = 16'd500;
  localparam logic [HOLD_W-1:0]    HOLD_RESET     = 22'd30000;
  localparam logic [HBEAT_W-1:0]   HBEAT_RESET    = 22'd60000;

  typedef enum logic [2:0] {
    REG_CONFIRM_COUNT = 3'd0,
    REG_BEEP_ON_MS    = 3'd1,
    REG_BEEP_OFF_MS   = 3'd2,
    REG_ALARM_HOLD_MS = 3'd3,
    REG_HEARTBEAT_MS  = 3'd4
  } reg_index_t;

  typedef enum logic {
    ACT_SAMPLE  = 1'b0,
    ACT_OUTCOME = 1'b1
  } action_t;

endpackage

// ===== sv/fabr_if.sv =====
// Valid/ready channel interfaces for the flame alarm block.
// The item channel carries samples and report outcomes; the result channel carries outputs.
`timescale 1ns / 1ps
interface fabr_item_if
  import fabr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             action;
  logic [NOW_W-1:0] now_ms;
  logic             flame_raw;
  logic             report_ok;

  modport source (output valid, action, now_ms, flame_raw, report_ok, input ready);
  modport sink   (input valid, action, now_ms, flame_raw, report_ok, output ready);
endinterface

interface fabr_result_if;
  logic valid;
  logic ready;
  logic beeper_sound;
  logic alarm_active;
  logic fire_confirmed;
  logic report_request;

  modport source (output valid, beeper_sound, alarm_active, fire_confirmed, report_request,
                  input ready);
  modport sink   (input valid, beeper_sound, alarm_active, fire_confirmed, report_request,
                  output ready);
endinterface

// ===== sv/flame_alarm_beeper_reporter.sv =====
// Flame alarm beeper and report scheduler: one result transaction for every item
// transaction, one item per clock cycle sustained; throughput is set only by the result
// channel's ready. An accepted item is registered, then compares and subtracts on the
// held state produce the result register. Times are kept modulo 2^TIME_BITS.
// Registers must be written over the APB port only while idle; the block does not check.
`timescale 1ns / 1ps
module flame_alarm_beeper_reporter
  import fabr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  fabr_item_if.sink             item,
  fabr_result_if.source         res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;
  localparam int HB_W  = ((TIME_BITS > NOW_W) ? TIME_BITS : NOW_W) + 1;

  // Configuration registers
  logic [CONFIRM_W-1:0] confirm_count;
  logic [BEEP_W-1:0]    beep_on_ms;
  logic [BEEP_W-1:0]    beep_off_ms;
  logic [HOLD_W-1:0]    alarm_hold_ms;
  logic [HBEAT_W-1:0]   heartbeat_ms;
  reg_index_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_count <= CONFIRM_RESET;
      beep_on_ms    <= BEEP_ON_RESET;
      beep_off_ms   <= BEEP_OFF_RESET;
      alarm_hold_ms <= HOLD_RESET;
      heartbeat_ms  <= HBEAT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_CONFIRM_COUNT: confirm_count <= pwdata[CONFIRM_W-1:0];
        REG_BEEP_ON_MS:    beep_on_ms    <= pwdata[BEEP_W-1:0];
        REG_BEEP_OFF_MS:   beep_off_ms   <= pwdata[BEEP_W-1:0];
        REG_ALARM_HOLD_MS: alarm_hold_ms <= pwdata[HOLD_W-1:0];
        REG_HEARTBEAT_MS:  heartbeat_ms  <= pwdata[HBEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CONFIRM_COUNT: prdata = APB_DATA_W'(confirm_count);
      REG_BEEP_ON_MS:    prdata = APB_DATA_W'(beep_on_ms);
      REG_BEEP_OFF_MS:   prdata = APB_DATA_W'(beep_off_ms);
      REG_ALARM_HOLD_MS: prdata = APB_DATA_W'(alarm_hold_ms);
      REG_HEARTBEAT_MS:  prdata = APB_DATA_W'(heartbeat_ms);
      default:           prdata = '0;
    endcase
  end

  // Input register stage
  logic             s1_valid;
  logic             s1_action;
  logic [NOW_W-1:0] s1_now_ms;
  logic             s1_flame_raw;
  logic             s1_report_ok;
  logic             advance;

  // Result register stage
  logic out_valid;
  logic out_beeper;
  logic out_alarm;
  logic out_fire;
  logic out_request;

  assign advance    = !out_valid || res.ready;
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_action    <= item.action;
      s1_now_ms    <= item.now_ms;
      s1_flame_raw <= item.flame_raw;
      s1_report_ok <= item.report_ok;
    end
  end

  // Alarm and report state
  logic [CONFIRM_W-1:0] hit_run,          hit_run_next;
  logic                 prev_fire,        prev_fire_next;
  logic                 alarm_on,         alarm_on_next;
  logic                 beep_phase,       beep_phase_next;
  logic [TIME_BITS-1:0] alarm_start,      alarm_start_next;
  logic [TIME_BITS-1:0] phase_start,      phase_start_next;
  logic [TIME_BITS-1:0] last_report_time, last_report_time_next;
  logic                 alarm_dirty,      alarm_dirty_next;
  logic                 fire_dirty,       fire_dirty_next;
  logic                 retry_pending,    retry_pending_next;
  logic                 request;

  logic [TIME_BITS-1:0] now_t;
  logic                 fire_now;
  logic                 changed;
  logic                 start;
  logic                 on1;
  logic                 phase1;
  logic [TIME_BITS-1:0] pstart1;
  logic [TIME_BITS-1:0] astart1;
  logic [TIME_BITS-1:0] phase_el;
  logic [TIME_BITS-1:0] alarm_el;
  logic [BEEP_W-1:0]    phase_limit;
  logic                 toggle;
  logic                 phase2;
  logic                 stop;
  logic [TIME_BITS-1:0] hb_el;
  logic [HB_W-1:0]      hb_wrap;

  always_comb begin
    now_t = TIME_BITS'(s1_now_ms);

    // Debounce: the run saturates at the confirm count, one miss clears it.
    if (s1_flame_raw) begin
      hit_run_next = (hit_run < confirm_count) ? hit_run + 1'b1 : hit_run;
    end else begin
      hit_run_next = '0;
    end
    fire_now = (hit_run_next >= confirm_count);
    changed  = (fire_now != prev_fire);

    start   = fire_now && !prev_fire && !alarm_on;
    on1     = alarm_on || start;
    phase1  = start ? 1'b1 : beep_phase;
    pstart1 = start ? now_t : phase_start;
    astart1 = start ? now_t : alarm_start;

    phase_el    = now_t - pstart1;
    phase_limit = phase1 ? beep_on_ms : beep_off_ms;
    toggle      = on1 && (CMP_W'(phase_el) >= CMP_W'(phase_limit));
    phase2      = toggle ? !phase1 : phase1;

    // An alarm whose start time reads zero is never stopped.
    alarm_el = now_t - astart1;
    stop     = !fire_now && on1 && (astart1 != '0) &&
               (CMP_W'(alarm_el) >= CMP_W'(alarm_hold_ms));

    // Heartbeat elapsed time is one short of the true difference after a wrap.
    hb_wrap = HB_W'(now_t) + HB_W'(HB_ALL_ONES) - HB_W'(last_report_time);
    if (now_t >= last_report_time) begin
      hb_el = now_t - last_report_time;
    end else begin
      hb_el = hb_wrap[TIME_BITS-1:0];
    end

    hit_run_next          = hit_run;
    prev_fire_next        = prev_fire;
    alarm_on_next         = alarm_on;
    beep_phase_next       = beep_phase;
    alarm_start_next      = alarm_start;
    phase_start_next      = phase_start;
    last_report_time_next = last_report_time;
    alarm_dirty_next      = alarm_dirty;
    fire_dirty_next       = fire_dirty;
    retry_pending_next    = retry_pending;
    request               = 1'b0;

    if (action_t'(s1_action) == ACT_OUTCOME) begin
      if (!s1_report_ok && fire_dirty) begin
        retry_pending_next = 1'b1;
      end
    end else begin
      hit_run_next     = s1_flame_raw ?
                         ((hit_run < confirm_count) ? hit_run + 1'b1 : hit_run) : '0;
      prev_fire_next   = fire_now;
      fire_dirty_next  = changed;
      alarm_on_next    = stop ? 1'b0 : on1;
      beep_phase_next  = stop ? 1'b0 : phase2;
      alarm_start_next = stop ? '0 : astart1;
      phase_start_next = toggle ? now_t : pstart1;
      alarm_dirty_next = alarm_dirty || start || toggle || stop;

      request = changed || alarm_dirty_next || retry_pending ||
                (CMP_W'(hb_el) >= CMP_W'(heartbeat_ms));
      if (request) begin
        retry_pending_next    = 1'b0;
        alarm_dirty_next      = 1'b0;
        last_report_time_next = now_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_run          <= '0;
      prev_fire        <= 1'b0;
      alarm_on         <= 1'b0;
      beep_phase       <= 1'b0;
      alarm_start      <= '0;
      phase_start      <= '0;
      last_report_time <= '0;
      alarm_dirty      <= 1'b0;
      fire_dirty       <= 1'b0;
      retry_pending    <= 1'b0;
    end else if (s1_valid && advance) begin
      hit_run          <= hit_run_next;
      prev_fire        <= prev_fire_next;
      alarm_on         <= alarm_on_next;
      beep_phase       <= beep_phase_next;
      alarm_start      <= alarm_start_next;
      phase_start      <= phase_start_next;
      last_report_time <= last_report_time_next;
      alarm_dirty      <= alarm_dirty_next;
      fire_dirty       <= fire_dirty_next;
      retry_pending    <= retry_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_beeper  <= beep_phase_next;
      out_alarm   <= alarm_on_next;
      out_fire    <= prev_fire_next;
      out_request <= request;
    end
  end

  assign res.valid          = out_valid;
  assign res.beeper_sound   = out_beeper;
  assign res.alarm_active   = out_alarm;
  assign res.fire_confirmed = out_fire;
  assign res.report_request = out_request;

  // The beeper can only sound while the alarm runs.
  a_beep_needs_alarm: assert property (@(posedge clk) disable iff (rst)
    !alarm_on |-> !beep_phase)
    else $error("beeper phase set without a running alarm");

  a_result_beep_needs_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_alarm |-> !out_beeper)
    else $error("result shows beeper sounding with alarm inactive");

  // A held item must not be dropped while the result side stalls.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("registered item lost during a stall");

  // A report request clears the pending retry and the alarm change flag.
  a_request_clears: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && (action_t'(s1_action) == ACT_SAMPLE) && request
    |=> !retry_pending && !alarm_dirty)
    else $error("report request did not clear pending flags");

  a_outcome_no_request: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && (action_t'(s1_action) == ACT_OUTCOME) |=> !out_request)
    else $error("outcome transaction produced a report request");

endmodule
